// File: hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam int FIELD_W  = 32;
  localparam int CAP_W    = 5;
  localparam int CAP_RESET = 16;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                       op;
    logic signed [FIELD_W-1:0]  lookup_key;
    logic signed [FIELD_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic signed [FIELD_W-1:0]  read_value;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic lookup;
    logic update;
  } cmd_t;

endpackage

// File: hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache with its APB register.
// A request is registered on acceptance, then looked up, then answered in the update step.
// The update step waits for a free result register; the next request may enter in it.
// The result register lets the next request enter while a result waits.
// Synchronous active-low reset clears all valid marks, the entry count and ranks.
// Reset sets the capacity register cap_r to 16; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lkvc_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lkvc_pkg::rsp_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  lkvc_pkg::cmd_t              cmd;
  logic [lkvc_pkg::CAP_W-1:0]  cap_r;
  logic                        reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RESET);
    end else if (reg_wr && (paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
      cap_r <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      lkvc_pkg::REG_CAPACITY: prdata = {{(32 - lkvc_pkg::CAP_W){1'b0}}, cap_r};
      default:                prdata = '0;
    endcase
  end

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_req   (in_data),
    .capacity (cap_r),
    .out_rsp  (out_data)
  );

endmodule

// File: hdl/lkvc_ctrl.sv
// Request sequencer for the LRU key-value cache: handshakes and step commands.
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lkvc_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       in_fire;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_UPDATE) && out_free);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd.load_req   = in_fire;
    cmd.lookup     = 1'b0;
    cmd.update     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = in_fire ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/lkvc_datapath.sv
// Entry storage, parallel key match and recency-rank update for the LRU cache.
module lkvc_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkvc_pkg::cmd_t                cmd,
  input  lkvc_pkg::req_t                in_req,
  input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
  output lkvc_pkg::rsp_t                out_rsp
);

  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
  localparam int FW    = lkvc_pkg::FIELD_W;

  lkvc_pkg::req_t         req_r;
  lkvc_pkg::rsp_t         rsp_r;
  logic [KEY_WIDTH-1:0]   keys_r   [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] vals_r   [MAX_ENTRIES];
  logic [IW-1:0]          rank_r   [MAX_ENTRIES];
  logic [IW-1:0]          rank_nxt [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  logic                   lk_hit_r;
  logic [IW-1:0]          lk_idx_r;
  logic [IW-1:0]          lk_rank_r;
  logic                   lk_full_r;
  logic [IW-1:0]          lk_vic_r;
  logic [VALUE_WIDTH-1:0] lk_val_r;

  logic                   hit_c;
  logic [IW-1:0]          idx_c;
  logic [IW-1:0]          rank_c;
  logic [IW-1:0]          vic_c;
  logic [VALUE_WIDTH-1:0] val_c;
  logic [CMP_W-1:0]       cap_c;
  logic                   full_c;

  logic [KEY_WIDTH+FW-1:0]   key_ext;
  logic [VALUE_WIDTH+FW-1:0] wval_ext;
  logic [KEY_WIDTH-1:0]      key_c;
  logic [VALUE_WIDTH-1:0]    wval_c;
  logic [FW+VALUE_WIDTH-1:0] rval_ext;
  logic [FW+VALUE_WIDTH-1:0] miss_ext;

  logic                   insert;
  logic                   promote;
  logic [IW-1:0]          slot;
  logic [CNT_W-1:0]       old_rank;
  logic [CNT_W-1:0]       last_rank;

  assign key_ext  = {{KEY_WIDTH{1'b0}}, req_r.lookup_key};
  assign wval_ext = {{VALUE_WIDTH{1'b0}}, req_r.write_value};
  assign key_c    = key_ext[KEY_WIDTH-1:0];
  assign wval_c   = wval_ext[VALUE_WIDTH-1:0];
  assign rval_ext = {{FW{1'b0}}, lk_val_r};
  assign miss_ext = {{FW{1'b0}}, {VALUE_WIDTH{1'b1}}};
  assign last_rank = count_r - 1'b1;

  // Lookup: keys are unique among valid entries, so matches are one-hot.
  always_comb begin
    hit_c  = 1'b0;
    idx_c  = '0;
    rank_c = '0;
    vic_c  = '0;
    val_c  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (valid_r[i] && (keys_r[i] == key_c)) begin
        hit_c  = 1'b1;
        idx_c  = idx_c | IW'(i);
        rank_c = rank_c | rank_r[i];
        val_c  = val_c | vals_r[i];
      end
      if (valid_r[i] && (CNT_W'(rank_r[i]) == last_rank)) begin
        vic_c = vic_c | IW'(i);
      end
    end
    cap_c = CMP_W'(capacity);
    if (cap_c == '0) begin
      cap_c = CMP_W'(1);
    end else if (cap_c > CMP_W'(MAX_ENTRIES)) begin
      cap_c = CMP_W'(MAX_ENTRIES);
    end
    full_c = (CMP_W'(count_r) >= cap_c);
  end

  // Update: valid slots are always 0..count-1, so a free slot is at count.
  always_comb begin
    insert   = (req_r.op == lkvc_pkg::OP_PUT) && !lk_hit_r;
    promote  = lk_hit_r || insert;
    slot     = lk_hit_r ? lk_idx_r : (lk_full_r ? lk_vic_r : count_r[IW-1:0]);
    old_rank = lk_hit_r ? CNT_W'(lk_rank_r) : (lk_full_r ? last_rank : count_r);
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (promote) begin
        if (IW'(i) == slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (CNT_W'(rank_r[i]) < old_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
    if (insert) begin
      valid_nxt[slot] = 1'b1;
      if (!lk_full_r) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
    if (cmd.lookup) begin
      lk_hit_r  <= hit_c;
      lk_idx_r  <= idx_c;
      lk_rank_r <= rank_c;
      lk_full_r <= full_c;
      lk_vic_r  <= vic_c;
      lk_val_r  <= val_c;
    end
    if (cmd.update) begin
      if (req_r.op == lkvc_pkg::OP_PUT) begin
        if (insert) begin
          keys_r[slot] <= key_c;
        end
        vals_r[slot] <= wval_c;
      end
      rsp_r.hit <= lk_hit_r;
      if (req_r.op == lkvc_pkg::OP_PUT) begin
        rsp_r.read_value <= '0;
      end else if (lk_hit_r) begin
        rsp_r.read_value <= rval_ext[FW-1:0];
      end else begin
        rsp_r.read_value <= miss_ext[FW-1:0];
      end
    end
  end

  assign out_rsp = rsp_r;

endmodule
